// ----- rtl/tfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// tfsa_pkg
// types, codes and helpers shared by the force accumulator modules
// ----------------------------------------------------------------------------
`default_nettype none

package tfsa_pkg;

  localparam int IN_DATA_W  = 400;
  localparam int OUT_DATA_W = 144;

  localparam logic [2:0] FN_TWRITE    = 3'd0;
  localparam logic [2:0] FN_PART      = 3'd1;
  localparam logic [2:0] FN_PART_EMIT = 3'd2;
  localparam logic [2:0] FN_NODE      = 3'd3;
  localparam logic [2:0] FN_NODE_EMIT = 3'd4;

  localparam logic REG_BIN_WIDTH     = 1'b0;
  localparam logic REG_INV_BIN_WIDTH = 1'b1;

  localparam logic [24:0] BIN_WIDTH_RST     = 25'd24576;
  localparam logic [31:0] INV_BIN_WIDTH_RST = 32'd44739242;

  localparam logic [63:0] PROD_LIM = 64'h00FF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {SH_RAW, SH_12, SH_16, SH_20, SH_24} sh_t;

  typedef enum logic [5:0] {
    OP_SQX, OP_SQY, OP_SQZ, OP_SQRT, OP_BIN, OP_BW,
    OP_RD0, OP_F0, OP_RD1, OP_F1, OP_RD2, OP_F2, OP_S,
    OP_Q11, OP_Q12, OP_Q13, OP_Q21, OP_Q22, OP_Q23, OP_Q31, OP_Q32, OP_Q33,
    OP_QQ1, OP_QQ2, OP_QQ3, OP_T1, OP_T2, OP_T3,
    OP_DX, OP_EX, OP_DY, OP_EY, OP_DZ, OP_EZ, OP_END
  } op_t;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_MUL, S_SQRT, S_ACC} state_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic twrite;
    logic mul_start;
    logic sqrt_init;
    logic sqrt_step;
    logic rd_en;
    logic acc_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_busy;
  } sts_t;

  // step list: shared head, then particle or node tail
  function automatic op_t prog_op(input logic node, input logic [5:0] pc);
    op_t op;
    op = OP_END;
    case (pc)
      6'd0: op = OP_SQX;
      6'd1: op = OP_SQY;
      6'd2: op = OP_SQZ;
      6'd3: op = OP_SQRT;
      6'd4: op = OP_BIN;
      6'd5: op = OP_BW;
      6'd6: op = OP_RD0;
      6'd7: op = OP_F0;
      6'd8: op = node ? OP_RD1 : OP_S;
      6'd9: op = node ? OP_F1 : OP_DX;
      6'd10: op = node ? OP_RD2 : OP_DY;
      6'd11: op = node ? OP_F2 : OP_DZ;
      6'd12: op = node ? OP_Q11 : OP_END;
      6'd13: op = OP_Q12;
      6'd14: op = OP_Q13;
      6'd15: op = OP_Q21;
      6'd16: op = OP_Q22;
      6'd17: op = OP_Q23;
      6'd18: op = OP_Q31;
      6'd19: op = OP_Q32;
      6'd20: op = OP_Q33;
      6'd21: op = OP_QQ1;
      6'd22: op = OP_QQ2;
      6'd23: op = OP_QQ3;
      6'd24: op = OP_T1;
      6'd25: op = OP_T2;
      6'd26: op = OP_T3;
      6'd27: op = OP_DX;
      6'd28: op = OP_EX;
      6'd29: op = OP_DY;
      6'd30: op = OP_EY;
      6'd31: op = OP_DZ;
      6'd32: op = OP_EZ;
      default: op = OP_END;
    endcase
    return op;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [64:0] v);
    logic [47:0] r;
    if (v > 65'sh0_7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
    else if (v < -65'sh0_8000_0000_0000) r = 48'h8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tfsa_ram.sv -----
// ----------------------------------------------------------------------------
// tfsa_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tfsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 12288
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tfsa_mul.sv -----
// ----------------------------------------------------------------------------
// tfsa_mul
// signed 63x63 bit multiply from four 32x32 partial products, then floor
// shift and saturation to +-(2^56-1)
// ----------------------------------------------------------------------------
`default_nettype none

module tfsa_mul
  import tfsa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  input  wire sh_t                sh,
  output logic                    done,
  output logic signed [63:0]      res,
  output logic        [63:0]      raw
);

  logic [62:0]  am_r, bm_r;
  logic         neg_r;
  sh_t          sh_r;
  logic [127:0] acc_r;
  logic [2:0]   step_r;
  logic         busy_r, done_r;
  logic signed [63:0] res_r;
  logic [63:0]  raw_r;

  logic [63:0]  a_abs, b_abs;
  logic [31:0]  asel, bsel;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [4:0]   shamt;
  logic [127:0] shifted, dmask;
  logic         inc;
  logic [64:0]  mag;
  logic [63:0]  lim_mag;

  assign a_abs = a[63] ? 64'(-a) : 64'(a);
  assign b_abs = b[63] ? 64'(-b) : 64'(b);

  always_comb begin
    case (step_r)
      3'd0: begin asel = am_r[31:0];          bsel = bm_r[31:0]; end
      3'd1: begin asel = am_r[31:0];          bsel = {1'b0, bm_r[62:32]}; end
      3'd2: begin asel = {1'b0, am_r[62:32]}; bsel = bm_r[31:0]; end
      default: begin asel = {1'b0, am_r[62:32]}; bsel = {1'b0, bm_r[62:32]}; end
    endcase
    pp = asel * bsel;
    case (step_r)
      3'd0: pp_sh = {64'd0, pp};
      3'd1, 3'd2: pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  always_comb begin
    case (sh_r)
      SH_12: shamt = 5'd12;
      SH_16: shamt = 5'd16;
      SH_20: shamt = 5'd20;
      SH_24: shamt = 5'd24;
      default: shamt = 5'd0;
    endcase
    shifted = acc_r >> shamt;
    dmask   = (128'd1 << shamt) - 128'd1;
    inc     = neg_r && (|(acc_r & dmask));
    mag     = {1'b0, shifted[63:0]} + {64'd0, inc};
    lim_mag = ((|shifted[127:64]) || (mag > {1'b0, PROD_LIM})) ? PROD_LIM : mag[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= a_abs[62:0];
      bm_r  <= b_abs[62:0];
      neg_r <= a[63] ^ b[63];
      sh_r  <= sh;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r == 3'd4) begin
        res_r <= neg_r ? -$signed(lim_mag) : $signed(lim_mag);
        raw_r <= acc_r[63:0];
      end else begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign raw  = raw_r;

endmodule

`default_nettype wire

// ----- rtl/tfsa_dp.sv -----
// ----------------------------------------------------------------------------
// tfsa_dp
// datapath: item registers, square root, table store, shared multiplier,
// running sums and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tfsa_dp
  import tfsa_pkg::*;
#(
  parameter int TABLE_BINS = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [31:0]           cfg_wdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int DEPTH = 3 * TABLE_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BINW  = $clog2(TABLE_BINS);

  logic [24:0] bw_r;
  logic [31:0] ibw_r;

  logic signed [31:0] x_r, y_r, z_r, qxx_r, qyy_r, qzz_r, tr_r;
  logic        [31:0] m_r;
  logic signed [23:0] qxy_r, qxz_r, qyz_r;

  logic [63:0] d2_r, v_r, r_r, bit_r;
  logic [BINW-1:0] bin_r;
  logic signed [31:0] frac_r, f0_r, f1_r, f2_r;
  logic signed [63:0] q1_r, q2_r, q3_r, qq_r, t_r, dx_r, dy_r, dz_r;
  logic signed [47:0] sum_x_r, sum_y_r, sum_z_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic out_valid_r;

  logic signed [63:0] op_a, op_b, res, f1x2;
  sh_t         op_sh;
  logic        mul_done;
  logic [63:0] raw, rb;
  logic        sq_ge;
  logic [63:0] rd_data;
  logic [31:0] rd_base;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        ram_we;
  logic signed [63:0] tval, frac_d;
  logic [47:0] nx, ny, nz;

  // item fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_tdata[31:0];
      y_r   <= in_tdata[63:32];
      z_r   <= in_tdata[95:64];
      m_r   <= in_tdata[127:96];
      qxx_r <= in_tdata[159:128];
      qyy_r <= in_tdata[191:160];
      qzz_r <= in_tdata[223:192];
      qxy_r <= {in_tdata[286:266], 3'b000};
      qxz_r <= {in_tdata[265:245], 3'b000};
      qyz_r <= {in_tdata[244:224], 3'b000};
      tr_r  <= in_tdata[318:287];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r  <= BIN_WIDTH_RST;
      ibw_r <= INV_BIN_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIN_WIDTH: bw_r <= cfg_wdata[24:0];
        REG_INV_BIN_WIDTH: ibw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // table store
  assign wr_addr = AW'({18'd0, in_tdata[332:319]});
  assign ram_we  = cmd.twrite && ({18'd0, in_tdata[332:319]} < 32'(DEPTH));

  always_comb begin
    case (cmd.op)
      OP_RD1: rd_base = 32'(TABLE_BINS);
      OP_RD2: rd_base = 32'(2 * TABLE_BINS);
      default: rd_base = 32'd0;
    endcase
    rd_addr = AW'(rd_base + 32'(bin_r));
  end

  tfsa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (in_tdata[396:333]),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // operand selection
  assign f1x2 = 64'(f1_r) <<< 1;

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sh = SH_RAW;
    case (cmd.op)
      OP_SQX: begin op_a = 64'(x_r); op_b = 64'(x_r); end
      OP_SQY: begin op_a = 64'(y_r); op_b = 64'(y_r); end
      OP_SQZ: begin op_a = 64'(z_r); op_b = 64'(z_r); end
      OP_BIN: begin op_a = $signed({32'd0, r_r[31:0]}); op_b = $signed({32'd0, ibw_r}); end
      OP_BW:  begin op_a = $signed(64'(bin_r)); op_b = $signed({39'd0, bw_r}); end
      OP_F0, OP_F1, OP_F2: begin
        op_a = 64'($signed(rd_data[31:0])); op_b = 64'(frac_r); op_sh = SH_24;
      end
      OP_S:   begin op_a = 64'(f0_r); op_b = $signed({32'd0, m_r}); op_sh = SH_12; end
      OP_Q11: begin op_a = 64'(qxx_r); op_b = 64'(x_r); op_sh = SH_16; end
      OP_Q12: begin op_a = 64'(qxy_r); op_b = 64'(y_r); op_sh = SH_16; end
      OP_Q13: begin op_a = 64'(qxz_r); op_b = 64'(z_r); op_sh = SH_16; end
      OP_Q21: begin op_a = 64'(qxy_r); op_b = 64'(x_r); op_sh = SH_16; end
      OP_Q22: begin op_a = 64'(qyy_r); op_b = 64'(y_r); op_sh = SH_16; end
      OP_Q23: begin op_a = 64'(qyz_r); op_b = 64'(z_r); op_sh = SH_16; end
      OP_Q31: begin op_a = 64'(qxz_r); op_b = 64'(x_r); op_sh = SH_16; end
      OP_Q32: begin op_a = 64'(qyz_r); op_b = 64'(y_r); op_sh = SH_16; end
      OP_Q33: begin op_a = 64'(qzz_r); op_b = 64'(z_r); op_sh = SH_16; end
      OP_QQ1: begin op_a = 64'(x_r); op_b = q1_r; op_sh = SH_24; end
      OP_QQ2: begin op_a = 64'(y_r); op_b = q2_r; op_sh = SH_24; end
      OP_QQ3: begin op_a = 64'(z_r); op_b = q3_r; op_sh = SH_24; end
      OP_T1:  begin op_a = $signed({32'd0, m_r}); op_b = 64'(f0_r); op_sh = SH_12; end
      OP_T2:  begin op_a = 64'(tr_r); op_b = 64'(f1_r); op_sh = SH_12; end
      OP_T3:  begin op_a = qq_r; op_b = 64'(f2_r); op_sh = SH_20; end
      OP_DX:  begin op_a = 64'(x_r); op_b = t_r; op_sh = SH_24; end
      OP_DY:  begin op_a = 64'(y_r); op_b = t_r; op_sh = SH_24; end
      OP_DZ:  begin op_a = 64'(z_r); op_b = t_r; op_sh = SH_24; end
      OP_EX:  begin op_a = q1_r; op_b = f1x2; op_sh = SH_20; end
      OP_EY:  begin op_a = q2_r; op_b = f1x2; op_sh = SH_20; end
      OP_EZ:  begin op_a = q3_r; op_b = f1x2; op_sh = SH_20; end
      default: ;
    endcase
  end

  tfsa_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (op_a),
    .b     (op_b),
    .sh    (op_sh),
    .done  (mul_done),
    .res   (res),
    .raw   (raw)
  );

  assign tval   = 64'($signed(rd_data[63:32])) + res;
  assign frac_d = $signed({32'd0, r_r[31:0]}) - $signed(raw);
  assign rb     = r_r + bit_r;
  assign sq_ge  = v_r >= rb;

  // square root and result write-back
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      v_r   <= d2_r;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (sq_ge) begin
        v_r <= v_r - rb;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (mul_done) begin
      case (cmd.op)
        OP_SQX: d2_r <= raw;
        OP_SQY, OP_SQZ: d2_r <= d2_r + raw;
        OP_BIN: begin
          if (raw[63:40] > 24'(TABLE_BINS - 1)) bin_r <= BINW'(TABLE_BINS - 1);
          else bin_r <= raw[40 +: BINW];
        end
        OP_BW:  frac_r <= sat32(frac_d);
        OP_F0:  f0_r <= sat32(tval);
        OP_F1:  f1_r <= sat32(tval);
        OP_F2:  f2_r <= sat32(tval);
        OP_S, OP_T1: t_r <= res;
        OP_T2, OP_T3: t_r <= t_r + res;
        OP_Q11: q1_r <= res;
        OP_Q12, OP_Q13: q1_r <= q1_r + res;
        OP_Q21: q2_r <= res;
        OP_Q22, OP_Q23: q2_r <= q2_r + res;
        OP_Q31: q3_r <= res;
        OP_Q32, OP_Q33: q3_r <= q3_r + res;
        OP_QQ1: qq_r <= res;
        OP_QQ2, OP_QQ3: qq_r <= qq_r + res;
        OP_DX:  dx_r <= res;
        OP_EX:  dx_r <= dx_r + res;
        OP_DY:  dy_r <= res;
        OP_EY:  dy_r <= dy_r + res;
        OP_DZ:  dz_r <= res;
        OP_EZ:  dz_r <= dz_r + res;
        default: ;
      endcase
    end
  end

  // running sums and result register
  assign nx = sat48(65'(sum_x_r) + 65'(dx_r));
  assign ny = sat48(65'(sum_y_r) + 65'(dy_r));
  assign nz = sat48(65'(sum_z_r) + 65'(dz_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.acc_en) begin
        if (cmd.emit) begin
          sum_x_r     <= '0;
          sum_y_r     <= '0;
          sum_z_r     <= '0;
          out_valid_r <= 1'b1;
        end else begin
          sum_x_r <= nx;
          sum_y_r <= ny;
          sum_z_r <= nz;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && cmd.emit) begin
      out_data_r <= {nz, ny, nx};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.mul_done = mul_done;
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

`default_nettype wire

// ----- rtl/tfsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfsa_ctrl
// controller: accepts items and steps the datapath through its step list
// ----------------------------------------------------------------------------
`default_nettype none

module tfsa_ctrl
  import tfsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [2:0] in_func,
  output logic            in_tready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       node_r, node_nxt, emit_r, emit_nxt;
  op_t        op;
  logic       compute, is_rd, is_mul;

  assign op      = prog_op(node_r, pc_r);
  assign compute = in_func inside {[FN_PART:FN_NODE_EMIT]};
  assign is_rd   = op inside {OP_RD0, OP_RD1, OP_RD2};
  assign is_mul  = !(op inside {OP_SQRT, OP_RD0, OP_RD1, OP_RD2, OP_END});

  // next state
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    node_nxt  = node_r;
    emit_nxt  = emit_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && compute) begin
          state_nxt = S_RUN;
          pc_nxt    = '0;
          node_nxt  = in_func inside {FN_NODE, FN_NODE_EMIT};
          emit_nxt  = in_func inside {FN_PART_EMIT, FN_NODE_EMIT};
        end
      end
      S_RUN: begin
        if (op == OP_END) begin
          state_nxt = S_ACC;
        end else if (op == OP_SQRT) begin
          state_nxt = S_SQRT;
          cnt_nxt   = '0;
        end else if (is_rd) begin
          pc_nxt = pc_r + 6'd1;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_RUN;
          pc_nxt    = pc_r + 6'd1;
        end
      end
      S_SQRT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_RUN;
          pc_nxt    = pc_r + 6'd1;
        end
      end
      S_ACC: begin
        if (!(emit_r && sts.out_busy)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      cnt_r   <= '0;
      node_r  <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
      node_r  <= node_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // outputs
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.op        = op;
    cmd.load      = (state_r == S_IDLE) && in_tvalid && compute;
    cmd.twrite    = (state_r == S_IDLE) && in_tvalid && (in_func == FN_TWRITE);
    cmd.mul_start = (state_r == S_RUN) && is_mul;
    cmd.sqrt_init = (state_r == S_RUN) && (op == OP_SQRT);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.rd_en     = (state_r == S_RUN) && is_rd;
    cmd.acc_en    = (state_r == S_ACC) && !(emit_r && sts.out_busy);
    cmd.emit      = emit_r;
  end

endmodule

`default_nettype wire

// ----- rtl/tree_force_spline_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// tree_force_spline_accumulator_core
// short-range force on one target from table-interpolated particle and node
// terms, with a loadable correction table and emitted saturated sums
// ----------------------------------------------------------------------------
//  channel   direction  ports              contents
//  in        in         in_t*              item: func in tuser, fields in tdata
//  out       out        out_t*             accel x, y, z sums
//  cfg       in         cfg_*              bin_width, inverse_bin_width
//
//  table writes and unused codes are taken without leaving idle
//  particle and node items run their step list on the shared multiplier (four 32x32
//  partial products each) and the bit-serial square root; one item in work
//  synchronous active-low reset clears sums, result valid, configuration and control
//  a stalled result holds the block only when the next emit is due
// ----------------------------------------------------------------------------
`default_nettype none

module tree_force_spline_accumulator_core
  import tfsa_pkg::*;
#(
  parameter int TABLE_BINS = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // offset_x, offset_y, offset_z, source_mass, quad_xx, quad_yy, quad_zz,
  // quad_offdiag, quad_trace, table_address, table_entry, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  wire logic [2:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // accel_x, accel_y, accel_z
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [31:0]           cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  tfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tfsa_dp #(.TABLE_BINS(TABLE_BINS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ap_busy_after_item : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FN_PART || in_tuser == FN_PART_EMIT ||
     in_tuser == FN_NODE || in_tuser == FN_NODE_EMIT)) |=> !in_tready)
    else $error("ready while an item is in work");

  ap_result_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.acc_en && cmd.emit))
    else $error("result without an emit");

  ap_mul_when_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !in_tready && !cmd.acc_en)
    else $error("multiply started outside an item");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tree force accumulator: directed and random items
// are predicted in order by a bit-true model of the table lookup, the
// multiplies and the saturated sums, and every emitted result is compared
// field by field under random idling on both sides and several bin settings
// ----------------------------------------------------------------------------
module tb_top;
  import tfsa_pkg::*;

  localparam int BINS = 4096;
  localparam int WORDS = 3 * BINS;
  localparam longint PLIM = 64'sh00FF_FFFF_FFFF_FFFF;
  localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -S48_MAX - 1;
  localparam longint I32_MAX = 64'sh7FFF_FFFF;
  localparam longint I32_MIN = -I32_MAX - 1;
  localparam int DRAIN_WAIT = 400;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [2:0]         func;
    logic signed [31:0] ox, oy, oz;
    logic [31:0]        mass;
    logic signed [31:0] qxx, qyy, qzz;
    logic [62:0]        offdiag;
    logic signed [31:0] trace;
    logic [13:0]        taddr;
    logic [63:0]        tentry;
  } src_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = FN_TWRITE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_BIN_WIDTH;
  logic [31:0] cfg_wdata = '0;

  tree_force_spline_accumulator_core #(.TABLE_BINS(BINS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // model state
  logic [63:0] tab_mem [WORDS];
  bit          tab_set [WORDS];
  longint      acc_x, acc_y, acc_z;
  longint unsigned bw_reg = BIN_WIDTH_RST;
  longint unsigned ibw_reg = INV_BIN_WIDTH_RST;

  src_item_t pending_items[$];
  logic [OUT_DATA_W-1:0] expected_accel[$];
  int send_idle = 17, recv_idle = 87;
  bit hold_req = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0;
  int errors = 0, mismatches = 0;
  int unsigned cycles = 0;

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(a*b / 2^sh) saturated to the product limit
  function automatic longint fxmul(longint a, longint b, int sh);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> sh;
    if (p > PLIM) return PLIM;
    if (p < -PLIM) return -PLIM;
    return longint'(p);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t <= 64'hFFFF_FFFF && t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned dist_of(src_item_t it);
    longint sx, sy, sz;
    sx = it.ox;
    sy = it.oy;
    sz = it.oz;
    return int_root(longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz));
  endfunction

  function automatic int bin_of(longint unsigned dlen);
    longint unsigned b;
    b = ((dlen >> 16) * ibw_reg + (((dlen & 64'hFFFF) * ibw_reg) >> 16)) >> 24;
    return b > BINS - 1 ? BINS - 1 : int'(b);
  endfunction

  function automatic longint interp(int comp, int bin, longint frac);
    logic [63:0] w;
    longint v, s;
    w = tab_mem[comp * BINS + bin];
    v = $signed(w[63:32]);
    s = $signed(w[31:0]);
    return clampv(v + fxmul(s, frac, 24), I32_MIN, I32_MAX);
  endfunction

  function automatic longint sx21(logic [20:0] v);
    longint r;
    r = $signed(v);
    return r * 8;
  endfunction

  task automatic predict_item(src_item_t it);
    longint x, y, z, m, frac, f0, f1, f2, dx, dy, dz, s;
    longint qxx, qyy, qzz, qxy, qxz, qyz, tr, q1, q2, q3, qq, t;
    longint unsigned dlen;
    int bin;
    if (it.func == FN_TWRITE) begin
      if (it.taddr < WORDS) begin
        tab_mem[it.taddr] = it.tentry;
        tab_set[it.taddr] = 1'b1;
      end
      return;
    end
    if (it.func > FN_NODE_EMIT) return;
    x = it.ox;
    y = it.oy;
    z = it.oz;
    m = {32'd0, it.mass};
    dlen = dist_of(it);
    bin = bin_of(dlen);
    frac = clampv(longint'(dlen) - longint'(bin * bw_reg), I32_MIN, I32_MAX);
    f0 = interp(0, bin, frac);
    if (it.func == FN_PART || it.func == FN_PART_EMIT) begin
      s = fxmul(f0, m, 12);
      dx = fxmul(x, s, 24);
      dy = fxmul(y, s, 24);
      dz = fxmul(z, s, 24);
    end else begin
      qxx = it.qxx;
      qyy = it.qyy;
      qzz = it.qzz;
      qxy = sx21(it.offdiag[62:42]);
      qxz = sx21(it.offdiag[41:21]);
      qyz = sx21(it.offdiag[20:0]);
      tr = it.trace;
      f1 = interp(1, bin, frac);
      f2 = interp(2, bin, frac);
      q1 = fxmul(qxx, x, 16) + fxmul(qxy, y, 16) + fxmul(qxz, z, 16);
      q2 = fxmul(qxy, x, 16) + fxmul(qyy, y, 16) + fxmul(qyz, z, 16);
      q3 = fxmul(qxz, x, 16) + fxmul(qyz, y, 16) + fxmul(qzz, z, 16);
      qq = fxmul(x, q1, 24) + fxmul(y, q2, 24) + fxmul(z, q3, 24);
      t = fxmul(m, f0, 12) + fxmul(tr, f1, 12) + fxmul(qq, f2, 20);
      dx = fxmul(x, t, 24) + fxmul(q1, 2 * f1, 20);
      dy = fxmul(y, t, 24) + fxmul(q2, 2 * f1, 20);
      dz = fxmul(z, t, 24) + fxmul(q3, 2 * f1, 20);
    end
    acc_x = clampv(acc_x + dx, S48_MIN, S48_MAX);
    acc_y = clampv(acc_y + dy, S48_MIN, S48_MAX);
    acc_z = clampv(acc_z + dz, S48_MIN, S48_MAX);
    if (it.func == FN_PART_EMIT || it.func == FN_NODE_EMIT) begin
      expected_accel.push_back({acc_z[47:0], acc_y[47:0], acc_x[47:0]});
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
    end
  endtask

  task automatic queue_item(src_item_t it);
    predict_item(it);
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rnd_word();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 24);
  endfunction

  function automatic logic [31:0] rnd_coord();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: return v;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      default: return v >>> $urandom_range(4, 12);
    endcase
  endfunction

  task automatic write_entry(int addr, logic [63:0] ent);
    src_item_t it;
    it = '{default: '0};
    it.func = FN_TWRITE;
    it.ox = $urandom;
    it.mass = $urandom;
    it.taddr = 14'(addr);
    it.tentry = ent;
    queue_item(it);
  endtask

  // loads any table word the source item will read and that is not yet set, before the item itself
  task automatic send_source(src_item_t it);
    int bin, ncomp;
    if (it.func != FN_TWRITE && it.func <= FN_NODE_EMIT) begin
      bin = bin_of(dist_of(it));
      ncomp = (it.func >= FN_NODE) ? 3 : 1;
      for (int c = 0; c < ncomp; c++)
        if (!tab_set[c * BINS + bin])
          write_entry(c * BINS + bin, {rnd_word(), rnd_word()});
    end
    queue_item(it);
  endtask

  function automatic src_item_t rnd_source(logic [2:0] func);
    src_item_t it;
    it.func = func;
    it.ox = rnd_coord();
    it.oy = rnd_coord();
    it.oz = rnd_coord();
    it.mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom >> $urandom_range(0, 28);
    it.qxx = rnd_word();
    it.qyy = rnd_word();
    it.qzz = rnd_word();
    it.offdiag = 63'({$urandom, $urandom});
    it.trace = rnd_word();
    it.taddr = 14'($urandom);
    it.tentry = {$urandom, $urandom};
    return it;
  endfunction

  task automatic random_phase(int n);
    src_item_t it;
    logic [2:0] f;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: f = 3'($urandom_range(5, 7));
        1: f = FN_TWRITE;
        2, 3, 4: f = FN_PART_EMIT;
        5, 6: f = FN_NODE_EMIT;
        7, 8, 9, 10, 11, 12: f = FN_PART;
        default: f = FN_NODE;
      endcase
      it = rnd_source(f);
      if (f == FN_TWRITE && $urandom_range(0, 1))
        it.taddr = 14'($urandom_range(0, WORDS - 1));
      send_source(it);
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_tvalid || expected_accel.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BIN_WIDTH) bw_reg = val & 32'h01FF_FFFF;
    else ibw_reg = val;
  endtask

  task automatic directed_items();
    src_item_t it;
    write_entry(0, 64'h7FFF_FFFF_8000_0000);
    write_entry(WORDS - 1, 64'h8000_0000_7FFF_FFFF);
    write_entry(WORDS, {$urandom, $urandom});
    write_entry(16383, 64'hFFFF_FFFF_FFFF_FFFF);
    it = rnd_source(FN_PART);
    it.ox = 0; it.oy = 0; it.oz = 0;
    send_source(it);
    it = rnd_source(FN_PART_EMIT);
    it.ox = 32'h8000_0000; it.oy = 32'h8000_0000; it.oz = 32'h8000_0000;
    it.mass = 32'hFFFF_FFFF;
    send_source(it);
    it = rnd_source(FN_NODE);
    it.ox = 32'h7FFF_FFFF; it.oy = 32'h7FFF_FFFF; it.oz = 32'h7FFF_FFFF;
    it.qxx = 32'h7FFF_FFFF; it.qyy = 32'h8000_0000; it.qzz = 32'h7FFF_FFFF;
    it.offdiag = '1; it.trace = 32'h8000_0000; it.mass = 0;
    send_source(it);
    it = rnd_source(FN_NODE_EMIT);
    it.offdiag = {21'h100000, 21'h0FFFFF, 21'h100000};
    send_source(it);
    for (int f = 5; f <= 7; f++) send_source(rnd_source(3'(f)));
    it = rnd_source(FN_PART_EMIT);
    it.ox = 32'h0000_1000; it.oy = 0; it.oz = 0;
    send_source(it);
    it = rnd_source(FN_NODE_EMIT);
    it.ox = 0; it.oy = 0; it.oz = 0;
    send_source(it);
    for (int i = 0; i < 6; i++) send_source(rnd_source(3'($urandom_range(1, 4))));
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        src_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.func;
        in_tdata <= {3'd0, it.tentry, it.taddr, it.trace, it.offdiag, it.qzz, it.qyy,
                     it.qxx, it.mass, it.oz, it.oy, it.ox};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_accel.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = expected_accel.pop_front();
        for (int k = 0; k < 3; k++)
          if (out_tdata[48*k +: 48] !== want[48*k +: 48]) begin
            errors++;
            if (mismatches++ < 10)
              $display("accel %0d mismatch: expected %h got %h", k,
                       want[48*k +: 48], out_tdata[48*k +: 48]);
          end
      end
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 3000;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL tree_force_spline_accumulator_core");
      $finish;
    end
  end

  initial begin
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    foreach (tab_set[i]) tab_set[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 17; recv_idle = 87;
    directed_items();
    random_phase(100);
    wait_idle();
    write_reg(REG_BIN_WIDTH, 32'd1);
    write_reg(REG_INV_BIN_WIDTH, 32'hFFFF_FFFF);
    random_phase(130);
    wait_idle();

    send_idle = 87; recv_idle = 17;
    write_reg(REG_BIN_WIDTH, 32'd16777216);
    write_reg(REG_INV_BIN_WIDTH, 32'd1);
    random_phase(130);
    wait_idle();
    write_reg(REG_BIN_WIDTH, $urandom_range(1, 16777216));
    write_reg(REG_INV_BIN_WIDTH, $urandom_range(1, 32'hFFFF_FFFF));
    random_phase(120);
    wait_idle();

    send_idle = 0; recv_idle = 0;
    write_reg(REG_BIN_WIDTH, 32'd49152);
    write_reg(REG_INV_BIN_WIDTH, 32'd22369621);
    hold_req = 1'b1;
    random_phase(140);
    wait_idle();
    write_reg(REG_BIN_WIDTH, BIN_WIDTH_RST);
    write_reg(REG_INV_BIN_WIDTH, INV_BIN_WIDTH_RST);
    random_phase(140);
    wait_idle();

    if (expected_accel.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS tree_force_spline_accumulator_core");
    end else begin
      $display("FAIL tree_force_spline_accumulator_core");
    end
    $finish;
  end

endmodule
